// ----- rtl/bitmap_block_allocator_unit_defines.svh -----
// Assertion helpers for the bitmap block allocator.
// Each expands to a labeled concurrent assertion, clocked on clk and
// disabled while arst_n is low.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BBA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap allocator check failed");

// antecedent implies consequent in the next cycle
`define BBA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap allocator check failed");

`endif

// ----- rtl/bba_pkg.sv -----
`default_nettype none

package bba_pkg;

	localparam int BLOCK_W    = 12;
	localparam int COUNT_W    = 13;
	localparam int FIELD_SPAN = 4096;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [BLOCK_W-1:0] target_block;
	} bba_req_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] granted_block;
		logic               no_space;
		logic               out_of_range;
	} bba_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FREE_RD,
		ST_DONE
	} bba_state_t;

endpackage

`default_nettype wire

// ----- rtl/bba_ram.sv -----
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bitmap_block_allocator_unit.sv -----
// First-fit block allocator over a used/free bitmap held in one synchronous
// RAM of MAP_WORD_BITS-bit words (MAP_WORD_BITS must be a power of two). After
// reset the block runs a clearing pass that writes zero to each of the
// ceil(MAX_BLOCKS / MAP_WORD_BITS) words (128 at the defaults) with in_ready
// low; configuration writes are taken throughout. An allocate reads bitmap
// words from the first up to and including the one holding a free bit, at
// most ceil(count / MAP_WORD_BITS) of them: the scan reads one word per cycle
// through the RAM read port. A free splits the block number into word and bit
// by shift and mask, then does one read and one write-back. A count of zero,
// or a free at or above the count, skips the scan and the write-back. One item
// is in work at a time; the result register lets the next item in while a
// result waits on out_ready.
`default_nettype none
`include "bitmap_block_allocator_unit_defines.svh"

module bitmap_block_allocator_unit
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS    = 4096,
	parameter int MAP_WORD_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COUNT_W-1:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bba_req_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bba_rsp_t                out_data
);

	localparam int MapWords  = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WordAw    = (MapWords > 1) ? $clog2(MapWords) : 1;
	localparam int BitAw     = $clog2(MAP_WORD_BITS);
	localparam int CapBlocks = (MAX_BLOCKS < FIELD_SPAN) ? MAX_BLOCKS : FIELD_SPAN;

	localparam logic [COUNT_W-1:0] CapCount  = COUNT_W'(CapBlocks);
	localparam logic [COUNT_W-1:0] WordBitsC = COUNT_W'(MAP_WORD_BITS);
	localparam logic [WordAw-1:0]  LastWord  = WordAw'(MapWords - 1);

	bba_state_t state_q, state_d;

	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       n_q;
	logic [COUNT_W-1:0]       base_q;
	logic [WordAw-1:0]        clr_q;
	logic [WordAw-1:0]        word_q;
	logic [BitAw-1:0]         bit_q;
	bba_rsp_t                 res_q;
	bba_rsp_t                 out_q;
	logic                     out_valid_q;

	logic                     ram_we;
	logic [WordAw-1:0]        ram_waddr;
	logic [MAP_WORD_BITS-1:0] ram_wdata;
	logic                     ram_re;
	logic [WordAw-1:0]        ram_raddr;
	logic [MAP_WORD_BITS-1:0] ram_rdata;

	logic                     in_xfer;
	logic                     out_load;
	logic [COUNT_W-1:0]       n_eff;
	logic                     req_oor;
	logic [WordAw-1:0]        tgt_word;
	logic [BitAw-1:0]         tgt_bit;
	bba_rsp_t                 res_init;

	logic [COUNT_W-1:0]       avail;
	logic [MAP_WORD_BITS-1:0] free_vec;
	logic                     found;
	logic [BitAw-1:0]         free_idx;
	logic                     last_scan;

	bba_ram #(
		.WIDTH(MAP_WORD_BITS),
		.DEPTH(MapWords)
	) u_map_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign n_eff   = (count_q > CapCount) ? CapCount : count_q;
	assign req_oor = {1'b0, in_data.target_block} >= n_eff;

	// block number to word index and bit position
	assign tgt_word = WordAw'(in_data.target_block >> BitAw);
	assign tgt_bit  = BitAw'(in_data.target_block);

	always_comb begin
		res_init = '0;
		if (in_data.kind == KIND_ALLOC) begin
			res_init.no_space = (n_eff == '0);
		end else begin
			res_init.out_of_range = req_oor;
		end
	end

	// scan of one word: bits at or above the count read as used
	assign avail = n_q - base_q;
	always_comb begin
		for (int i = 0; i < MAP_WORD_BITS; i++) begin
			free_vec[i] = !ram_rdata[i] && (COUNT_W'(i) < avail);
		end
	end
	assign found     = |free_vec;
	assign last_scan = (avail <= WordBitsC) || (word_q == LastWord);

	always_comb begin
		free_idx = '0;
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_idx = BitAw'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LastWord) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_data.kind == KIND_ALLOC) begin
						state_d = (n_eff == '0) ? ST_DONE : ST_SCAN;
					end else begin
						state_d = req_oor ? ST_DONE : ST_FREE_RD;
					end
				end
			end
			ST_SCAN: begin
				if (found || last_scan) begin
					state_d = ST_DONE;
				end
			end
			ST_FREE_RD: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// RAM and handshake controls
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				ram_re   = in_xfer && ((in_data.kind == KIND_ALLOC) || !req_oor);
				if (in_data.kind != KIND_ALLOC) begin
					ram_raddr = tgt_word;
				end
			end
			ST_SCAN: begin
				if (found) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << free_idx);
				end else if (!last_scan) begin
					ram_re    = 1'b1;
					ram_raddr = word_q + 1'b1;
				end
			end
			ST_FREE_RD: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << bit_q);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			count_q     <= COUNT_RESET;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				n_q    <= n_eff;
				base_q <= '0;
				word_q <= (in_data.kind == KIND_ALLOC) ? '0 : tgt_word;
				bit_q  <= tgt_bit;
				res_q  <= res_init;
			end
			ST_SCAN: begin
				if (found) begin
					res_q.granted_block <= BLOCK_W'(base_q + COUNT_W'(free_idx));
				end else if (last_scan) begin
					res_q.no_space <= 1'b1;
				end else begin
					word_q <= word_q + 1'b1;
					base_q <= base_q + WordBitsC;
				end
			end
			default: begin
			end
		endcase
	end

	`BBA_ASSERT_SAME(a_no_write_when_ready, in_ready, !ram_we)
	`BBA_ASSERT_NEXT(a_one_item_at_a_time, in_xfer, !in_ready)
	`BBA_ASSERT_NEXT(a_result_after_done, out_load, out_valid && (out_data == $past(res_q)))
	`BBA_ASSERT_SAME(a_clear_before_results, state_q == ST_CLEAR, !out_valid && !in_ready)

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;
	import bba_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 150;

	// Predicts every response from its own copy of the used map and the count
	// register, and checks the responses in order.
	class alloc_ledger;
		bit [FIELD_SPAN-1:0] busy_bits;
		logic [COUNT_W-1:0]  count_reg;
		bba_rsp_t            expected_q[$];
		int                  errors;
		int                  rsp_seen;

		function new();
			busy_bits = '0;
			count_reg = COUNT_RESET;
			errors    = 0;
			rsp_seen  = 0;
		endfunction

		function int eff_count();
			return (count_reg > FIELD_SPAN) ? FIELD_SPAN : int'(count_reg);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_count(logic [COUNT_W-1:0] value);
			count_reg = value;
		endfunction

		function void note_req(bba_req_t req);
			bba_rsp_t rsp;
			int       n;
			int       b;
			rsp = '0;
			n   = eff_count();
			if (req.kind == KIND_ALLOC) begin
				rsp.no_space = 1'b1;
				for (b = 0; b < n; b++) begin
					if (!busy_bits[b]) begin
						busy_bits[b]      = 1'b1;
						rsp.granted_block = BLOCK_W'(b);
						rsp.no_space      = 1'b0;
						break;
					end
				end
			end else if (int'(req.target_block) >= n) begin
				// bits above a lowered count stay as they are
				rsp.out_of_range = 1'b1;
			end else begin
				busy_bits[req.target_block] = 1'b0;
			end
			expected_q.push_back(rsp);
		endfunction

		task report(string msg);
			$display("mismatch at response %0d: %s", rsp_seen, msg);
			errors++;
		endtask

		task check_rsp(bba_rsp_t got);
			bba_rsp_t exp_rsp;
			rsp_seen++;
			if (expected_q.size() == 0) begin
				report("response with no request waiting");
			end else begin
				exp_rsp = expected_q.pop_front();
				if (got.granted_block !== exp_rsp.granted_block)
					report($sformatf("granted_block %0d, want %0d",
						got.granted_block, exp_rsp.granted_block));
				if (got.no_space !== exp_rsp.no_space)
					report($sformatf("no_space %b, want %b",
						got.no_space, exp_rsp.no_space));
				if (got.out_of_range !== exp_rsp.out_of_range)
					report($sformatf("out_of_range %b, want %b",
						got.out_of_range, exp_rsp.out_of_range));
			end
		endtask
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	bba_req_t           in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	bba_rsp_t           out_data;

	alloc_ledger ledger = new();
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          quiet_cycles  = 0;

	bitmap_block_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				ledger.note_count(cfg_data);
			if (in_valid && in_ready)
				ledger.note_req(in_data);
			if (out_valid && out_ready)
				ledger.check_rsp(out_data);
		end
	end

	// watchdog: cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// all tasks below are entered and left at a falling edge
	task automatic send_req(input logic kind, input logic [BLOCK_W-1:0] tgt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid             = 1'b1;
		in_data.kind         = kind;
		in_data.target_block = tgt;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (ledger.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly blocks likely to be in use, some anywhere, some at the count edge
	function automatic logic [BLOCK_W-1:0] pick_target(input int eff);
		int r;
		int hot;
		int t;
		r   = $urandom_range(99);
		hot = (eff < 64) ? eff : 64;
		if (r < 60)
			t = $urandom_range(hot + 1);
		else if (r < 85)
			t = $urandom_range(FIELD_SPAN - 1);
		else
			t = eff + $urandom_range(2) - 1;
		if (t < 0)
			t = 0;
		if (t > FIELD_SPAN - 1)
			t = FIELD_SPAN - 1;
		return BLOCK_W'(t);
	endfunction

	task automatic run_phase(input logic [COUNT_W-1:0] count_val, input int n_items,
		input int alloc_pct, input int pause_at);
		int i;
		drain();
		write_count(count_val);
		for (i = 0; i < n_items; i++) begin
			if (i == pause_at)
				drain();
			if ($urandom_range(99) < alloc_pct)
				send_req(KIND_ALLOC, BLOCK_W'($urandom_range(FIELD_SPAN - 1)));
			else
				send_req(KIND_FREE, pick_target(ledger.eff_count()));
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 16;
		recv_idle_pct = 46;

		// reset count, then free of a free block, reuse of a freed block
		send_req(KIND_ALLOC, '0);
		send_req(KIND_ALLOC, '1);
		send_req(KIND_ALLOC, '0);
		send_req(KIND_FREE, 12'd1);
		send_req(KIND_FREE, 12'd1);
		send_req(KIND_ALLOC, '0);
		send_req(KIND_FREE, 12'hFFF);
		send_req(KIND_FREE, 12'd0);
		// zero count manages nothing
		drain();
		write_count('0);
		send_req(KIND_ALLOC, '0);
		send_req(KIND_FREE, 12'd0);
		send_req(KIND_FREE, 12'hFFF);
		// count above the field span saturates
		drain();
		write_count('1);
		send_req(KIND_FREE, 12'hFFF);
		send_req(KIND_ALLOC, '0);
		// count lowered under blocks in use, then raised again
		drain();
		write_count(13'd2);
		send_req(KIND_ALLOC, '0);
		send_req(KIND_FREE, 12'd2);
		send_req(KIND_FREE, 12'd1);
		send_req(KIND_ALLOC, '0);
		drain();
		write_count(COUNT_RESET);
		send_req(KIND_ALLOC, '0);
		drain();
		write_count(13'd1);
		send_req(KIND_FREE, 12'd0);
		send_req(KIND_ALLOC, '0);
		send_req(KIND_ALLOC, '0);
		send_req(KIND_FREE, 12'hAAA);
		send_req(KIND_FREE, 12'h555);

		run_phase(13'd9, 70, 65, 30);
		run_phase(COUNT_RESET, 65, 60, -1);

		send_idle_pct = 46;
		recv_idle_pct = 16;
		run_phase(13'd1, 50, 50, -1);
		run_phase(COUNT_W'($urandom_range(20, 100)), 70, 60, -1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase('1, 70, 55, -1);
		run_phase(13'd33, 75, 70, -1);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (ledger.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
